// ===== design/rfcc_pkg.sv =====
package rfcc_pkg;

    localparam int LEVEL_W = 12;
    localparam int TEMP_W  = 12;
    localparam int BAND_W  = 8;
    localparam int DIV_W   = 8;
    localparam int SEC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    localparam logic [LEVEL_W-1:0] DEBOUNCE_RST  = 12'd3000;
    localparam logic [LEVEL_W-1:0] WET_RST       = 12'd400;
    localparam logic [LEVEL_W-1:0] FULL_RST      = 12'd600;
    localparam logic [DIV_W-1:0]   TPS_RST       = 8'd200;
    localparam logic [SEC_W-1:0]   TIMEOUT_RST   = 16'd300;
    localparam logic [BAND_W-1:0]  BAND_RST      = 8'd10;
    localparam logic [TEMP_W-1:0]  TEMP_MIN_RST  = 12'd20;
    localparam logic [TEMP_W-1:0]  TEMP_MAX_RST  = 12'd500;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE_LIMIT   = 3'd0,
        REG_WET_THRESHOLD    = 3'd1,
        REG_FULL_THRESHOLD   = 3'd2,
        REG_TICKS_PER_SECOND = 3'd3,
        REG_FILL_TIMEOUT     = 3'd4,
        REG_TEMP_BAND        = 3'd5,
        REG_TEMP_MIN         = 3'd6,
        REG_TEMP_MAX         = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_NORMAL = 2'd0,
        STATUS_ALARM  = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_EMPTY  = 2'd3
    } status_t;

    typedef struct packed {
        logic [TEMP_W-1:0] measured_tenths;
        logic [TEMP_W-1:0] target_tenths;
        logic              high_level_wet;
        logic              low_level_wet;
    } item_t;

    typedef struct packed {
        logic    second_pulse;
        logic    high_confirmed;
        logic    low_confirmed;
        status_t status;
        logic    cooler_on;
        logic    pump_on;
    } result_t;

endpackage

// ===== design/reservoir_fill_and_cooling_control.sv =====
// Throughput: one item per cycle while the output is not stalled.
// An accepted item passes an input register and then a result register, which
// decouple the two sides, with the level, timer and relay update between them.
// Reset (rst_n, async, active low): registers take their default values,
// low level counter preset to its debounce default, all other state cleared.
module reservoir_fill_and_cooling_control
    import rfcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // low_level_wet, high_level_wet, target_tenths[11:0], measured_tenths[11:0]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pump_on, cooler_on, status[1:0], low_confirmed, high_confirmed, second_pulse
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int ITEM_W   = $bits(item_t);
    localparam int RESULT_W = $bits(result_t);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
        if (advance)
            result_reg <= result_next;
    end

    rfcc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_en   (advance),
        .item      (item_reg),
        .result    (result_next)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, result_reg};

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled while input register empty");

    a_alarm_pump_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.status == STATUS_ALARM) |-> !result_reg.pump_on)
        else $error("pump running under fill alarm");

    a_cooler_needs_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.cooler_on |-> result_reg.low_confirmed)
        else $error("cooler on without low level confirmed");

    a_empty_not_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result_reg.status == STATUS_EMPTY) |-> !result_reg.low_confirmed)
        else $error("empty status with low level confirmed");

endmodule

// ===== design/rfcc_core.sv =====
module rfcc_core
    import rfcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              item_en,
    input  item_t             item,
    output result_t           result
);

    logic [LEVEL_W-1:0] debounce_reg;
    logic [LEVEL_W-1:0] wet_reg;
    logic [LEVEL_W-1:0] full_reg;
    logic [DIV_W-1:0]   tps_reg;
    logic [SEC_W-1:0]   timeout_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [TEMP_W-1:0]  temp_min_reg;
    logic [TEMP_W-1:0]  temp_max_reg;

    logic [LEVEL_W-1:0] low_count_reg, low_count_next;
    logic [LEVEL_W-1:0] high_count_reg, high_count_next;
    logic [DIV_W-1:0]   tick_div_reg, tick_div_next;
    logic [SEC_W-1:0]   fill_sec_reg, fill_sec_next;
    logic               filling_reg, filling_next;
    logic               pump_reg, pump_next;
    logic               cooler_reg, cooler_next;

    logic [DIV_W-1:0]   div_inc;
    logic               pulse;
    logic               low_ok;
    logic               high_ok;
    logic               timed_out;
    logic               in_limits;
    logic               above_lo;
    logic               below_hi;
    status_t            status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            wet_reg      <= WET_RST;
            full_reg     <= FULL_RST;
            tps_reg      <= TPS_RST;
            timeout_reg  <= TIMEOUT_RST;
            band_reg     <= BAND_RST;
            temp_min_reg <= TEMP_MIN_RST;
            temp_max_reg <= TEMP_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE_LIMIT:   debounce_reg <= cfg_data[LEVEL_W-1:0];
                REG_WET_THRESHOLD:    wet_reg      <= cfg_data[LEVEL_W-1:0];
                REG_FULL_THRESHOLD:   full_reg     <= cfg_data[LEVEL_W-1:0];
                REG_TICKS_PER_SECOND: tps_reg      <= cfg_data[DIV_W-1:0];
                REG_FILL_TIMEOUT:     timeout_reg  <= cfg_data[SEC_W-1:0];
                REG_TEMP_BAND:        band_reg     <= cfg_data[BAND_W-1:0];
                REG_TEMP_MIN:         temp_min_reg <= cfg_data[TEMP_W-1:0];
                REG_TEMP_MAX:         temp_max_reg <= cfg_data[TEMP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (!item.low_level_wet)
            low_count_next = '0;
        else if (low_count_reg < debounce_reg)
            low_count_next = low_count_reg + LEVEL_W'(1);
        else
            low_count_next = low_count_reg;

        if (!item.high_level_wet)
            high_count_next = '0;
        else if (high_count_reg < debounce_reg)
            high_count_next = high_count_reg + LEVEL_W'(1);
        else
            high_count_next = high_count_reg;

        div_inc       = tick_div_reg + DIV_W'(1);
        pulse         = (div_inc >= tps_reg);
        tick_div_next = pulse ? '0 : div_inc;

        fill_sec_next = fill_sec_reg;
        if (pulse)
        begin
            if (!filling_reg)
                fill_sec_next = '0;
            else if (fill_sec_reg != {SEC_W{1'b1}})
                fill_sec_next = fill_sec_reg + SEC_W'(1);
        end

        low_ok  = (low_count_next > wet_reg);
        high_ok = (high_count_next > wet_reg);

        in_limits = (item.measured_tenths > temp_min_reg)
                 && (item.measured_tenths < temp_max_reg);
        above_lo  = ({1'b0, item.measured_tenths} + {{(TEMP_W-BAND_W+1){1'b0}}, band_reg})
                 >= {1'b0, item.target_tenths};
        below_hi  = {1'b0, item.measured_tenths}
                 < ({1'b0, item.target_tenths} + {{(TEMP_W-BAND_W+1){1'b0}}, band_reg});

        cooler_next = cooler_reg;
        if (!low_ok)
            cooler_next = 1'b0;
        else if (in_limits)
            cooler_next = !(above_lo && below_hi);

        timed_out    = (fill_sec_next >= timeout_reg);
        pump_next    = pump_reg;
        filling_next = filling_reg;
        if (!timed_out)
        begin
            priority if (low_count_next == '0)
            begin
                pump_next    = 1'b1;
                filling_next = 1'b1;
            end
            else if (high_count_next >= wet_reg)
            begin
                pump_next    = 1'b0;
                filling_next = 1'b0;
            end
            else
            begin
                pump_next    = pump_reg;
                filling_next = filling_reg;
            end
        end

        priority if (timed_out)
        begin
            status    = STATUS_ALARM;
            pump_next = 1'b0;
        end
        else if (high_count_next >= full_reg)
            status = STATUS_FULL;
        else if (low_count_next == '0)
            status = STATUS_EMPTY;
        else
            status = STATUS_NORMAL;

        result.pump_on        = pump_next;
        result.cooler_on      = cooler_next;
        result.status         = status;
        result.low_confirmed  = low_ok;
        result.high_confirmed = high_ok;
        result.second_pulse   = pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_count_reg  <= DEBOUNCE_RST;
            high_count_reg <= '0;
            tick_div_reg   <= '0;
            fill_sec_reg   <= '0;
            filling_reg    <= 1'b0;
            pump_reg       <= 1'b0;
            cooler_reg     <= 1'b0;
        end
        else if (item_en)
        begin
            low_count_reg  <= low_count_next;
            high_count_reg <= high_count_next;
            tick_div_reg   <= tick_div_next;
            fill_sec_reg   <= fill_sec_next;
            filling_reg    <= filling_next;
            pump_reg       <= pump_next;
            cooler_reg     <= cooler_next;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    import rfcc_pkg::*;

    localparam int LATENCY       = 2;
    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 100;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 80;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // register copies
    logic [LEVEL_W-1:0] debounce_cfg;
    logic [LEVEL_W-1:0] wet_cfg;
    logic [LEVEL_W-1:0] full_cfg;
    logic [DIV_W-1:0]   tps_cfg;
    logic [SEC_W-1:0]   timeout_cfg;
    logic [BAND_W-1:0]  band_cfg;
    logic [TEMP_W-1:0]  tmin_cfg;
    logic [TEMP_W-1:0]  tmax_cfg;

    // controller state
    logic [LEVEL_W-1:0] low_cnt;
    logic [LEVEL_W-1:0] high_cnt;
    logic [DIV_W-1:0]   tick_div;
    logic [SEC_W-1:0]   fill_secs;
    bit                 filling_q;
    bit                 pump_q;
    bit                 cooler_q;

    result_t pending_outputs[$];

    bit src_idle;
    bit snk_idle;
    bit hold_req;
    int errors;
    int n_items;
    int n_checked;
    int n_writes;
    int n_alarm_ticks;
    int n_pump_ticks;
    int quiet_cycles;

    reservoir_fill_and_cooling_control u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] next_level(logic [LEVEL_W-1:0] count, bit wet);
        if (!wet)
            return '0;
        if (count < debounce_cfg)
            return count + 1'b1;
        return count;
    endfunction

    function automatic result_t predict_tick(item_t it);
        result_t r;
        bit      pulse;
        bit      low_ok;
        bit      high_ok;
        bit      timed_out;
        int      meas;
        int      lo;
        int      hi;
        low_cnt  = next_level(low_cnt, it.low_level_wet);
        high_cnt = next_level(high_cnt, it.high_level_wet);
        pulse    = 1'b0;
        tick_div = tick_div + 1'b1;
        if (tick_div >= tps_cfg)
        begin
            tick_div = '0;
            pulse    = 1'b1;
            if (filling_q)
            begin
                if (fill_secs != '1)
                    fill_secs = fill_secs + 1'b1;
            end
            else
                fill_secs = '0;
        end
        low_ok  = low_cnt > wet_cfg;
        high_ok = high_cnt > wet_cfg;
        meas = int'(it.measured_tenths);
        lo   = int'(it.target_tenths) - int'(band_cfg);
        hi   = int'(it.target_tenths) + int'(band_cfg);
        if (low_ok)
        begin
            if (meas > int'(tmin_cfg) && meas < int'(tmax_cfg))
                cooler_q = !(meas >= lo && meas < hi);
        end
        else
            cooler_q = 1'b0;
        timed_out = fill_secs >= timeout_cfg;
        if (!timed_out)
        begin
            if (low_cnt == '0)
            begin
                pump_q    = 1'b1;
                filling_q = 1'b1;
            end
            else if (high_cnt >= wet_cfg)
            begin
                pump_q    = 1'b0;
                filling_q = 1'b0;
            end
        end
        if (timed_out)
        begin
            r.status = STATUS_ALARM;
            pump_q   = 1'b0;
            n_alarm_ticks++;
        end
        else if (high_cnt >= full_cfg)
            r.status = STATUS_FULL;
        else if (low_cnt == '0)
            r.status = STATUS_EMPTY;
        else
            r.status = STATUS_NORMAL;
        if (pump_q)
            n_pump_ticks++;
        r.pump_on        = pump_q;
        r.cooler_on      = cooler_q;
        r.low_confirmed  = low_ok;
        r.high_confirmed = high_ok;
        r.second_pulse   = pulse;
        return r;
    endfunction

    function automatic item_t item_of(bit low_wet, bit high_wet, int tgt, int meas);
        item_t it;
        it.low_level_wet   = low_wet;
        it.high_level_wet  = high_wet;
        it.target_tenths   = TEMP_W'(tgt);
        it.measured_tenths = TEMP_W'(meas);
        return it;
    endfunction

    function automatic int pick(int lo, int hi, int typ_hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, typ_hi);
        endcase
    endfunction

    function automatic void compare_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_output(result_t got);
        result_t want;
        if (pending_outputs.size() == 0)
        begin
            errors++;
            $display("%0t: output item expected none got %h", $time, got);
            return;
        end
        want = pending_outputs.pop_front();
        n_checked++;
        compare_field("pump_on", want.pump_on, got.pump_on);
        compare_field("cooler_on", want.cooler_on, got.cooler_on);
        compare_field("status", want.status, got.status);
        compare_field("low_confirmed", want.low_confirmed, got.low_confirmed);
        compare_field("high_confirmed", want.high_confirmed, got.high_confirmed);
        compare_field("second_pulse", want.second_pulse, got.second_pulse);
    endtask

    task automatic send_item(item_t it);
        int gap;
        gap = src_idle ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(it);
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        pending_outputs.push_back(predict_tick(it));
        n_items++;
    endtask

    task automatic send_tick(bit low_wet, bit high_wet);
        int tgt;
        int meas;
        int span;
        span = int'(band_cfg) + 4;
        if (tmin_cfg <= tmax_cfg && $urandom_range(0, 3) != 0)
            tgt = $urandom_range(tmin_cfg, tmax_cfg);
        else
            tgt = $urandom_range(0, 4095);
        case ($urandom_range(0, 7))
            0: meas = $urandom_range(0, 4095);
            1: meas = $urandom_range(0, 1) ? 4095 : 0;
            default: meas = tgt + int'($urandom_range(0, 2 * span)) - span;
        endcase
        if (meas < 0)
            meas = 0;
        if (meas > 4095)
            meas = 4095;
        send_item(item_of(low_wet, high_wet, tgt, meas));
    endtask

    task automatic drain_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        case (idx)
            REG_DEBOUNCE_LIMIT:   debounce_cfg = LEVEL_W'(value);
            REG_WET_THRESHOLD:    wet_cfg      = LEVEL_W'(value);
            REG_FULL_THRESHOLD:   full_cfg     = LEVEL_W'(value);
            REG_TICKS_PER_SECOND: tps_cfg      = DIV_W'(value);
            REG_FILL_TIMEOUT:     timeout_cfg  = SEC_W'(value);
            REG_TEMP_BAND:        band_cfg     = BAND_W'(value);
            REG_TEMP_MIN:         tmin_cfg     = TEMP_W'(value);
            REG_TEMP_MAX:         tmax_cfg     = TEMP_W'(value);
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(item_of(1'b1, 1'b0, 250, 250));
        send_item(item_of(1'b1, 1'b0, 250, 300));
        send_item(item_of(1'b1, 1'b0, 250, 10));
        send_item(item_of(1'b1, 1'b1, 250, 500));
        send_item(item_of(1'b0, 1'b0, 4095, 0));
        send_item(item_of(1'b0, 1'b1, 100, 4095));
    endtask

    task automatic test_band_edges();
        write_reg(REG_TEMP_MIN, 0);
        write_reg(REG_TEMP_MAX, 4095);
        write_reg(REG_TEMP_BAND, 255);
        write_reg(REG_WET_THRESHOLD, 0);
        write_reg(REG_DEBOUNCE_LIMIT, 4095);
        send_item(item_of(1'b1, 1'b0, 0, 1));
        send_item(item_of(1'b1, 1'b0, 0, 255));
        send_item(item_of(1'b1, 1'b0, 4095, 3840));
        send_item(item_of(1'b1, 1'b0, 4095, 3839));
        send_item(item_of(1'b1, 1'b0, 4095, 4095));
        send_item(item_of(1'b1, 1'b0, 100, 0));
        write_reg(REG_TEMP_BAND, 0);
        send_item(item_of(1'b1, 1'b1, 2000, 2000));
    endtask

    task automatic test_level_limits();
        repeat (3) send_item(item_of(1'b1, 1'b1, 300, 200));
        write_reg(REG_DEBOUNCE_LIMIT, 2);
        repeat (2) send_item(item_of(1'b1, 1'b1, 300, 200));
        write_reg(REG_TICKS_PER_SECOND, 0);
        repeat (2) send_item(item_of(1'b1, 1'b0, 300, 200));
        write_reg(REG_DEBOUNCE_LIMIT, 4095);
        write_reg(REG_WET_THRESHOLD, 3);
        send_item(item_of(1'b0, 1'b0, 300, 200));
        repeat (3) send_item(item_of(1'b1, 1'b1, 300, 200));
    endtask

    task automatic test_fill_timer();
        write_reg(REG_FILL_TIMEOUT, 0);
        repeat (2) send_item(item_of(1'b0, 1'b0, 300, 200));
        write_reg(REG_FILL_TIMEOUT, 3);
        repeat (5) send_item(item_of(1'b0, 1'b0, 300, 200));
        write_reg(REG_FILL_TIMEOUT, 65535);
        repeat (2) send_item(item_of(1'b1, 1'b1, 300, 200));
    endtask

    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_req = 1'b1;
        repeat (40) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
        drain_outputs();
        src_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        int dl;
        int tmin;
        int first;
        int run;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // clear a latched alarm so the next setting starts with the fill stopped and its timer cleared
            if (fill_secs >= timeout_cfg)
            begin
                write_reg(REG_FILL_TIMEOUT, 65535);
                write_reg(REG_TICKS_PER_SECOND, 1);
                write_reg(REG_WET_THRESHOLD, 0);
                while (filling_q || fill_secs != '0)
                    send_tick(1'b1, 1'b1);
            end
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            dl = pick(1, 4095, 40);
            write_reg(REG_DEBOUNCE_LIMIT, dl);
            write_reg(REG_WET_THRESHOLD, pick(0, 4095, (dl < 50) ? dl : 50));
            write_reg(REG_FULL_THRESHOLD, pick(0, 4095, (dl < 80) ? dl : 80));
            write_reg(REG_TICKS_PER_SECOND, pick(1, 255, 6));
            write_reg(REG_FILL_TIMEOUT, pick(1, 65535, 25));
            write_reg(REG_TEMP_BAND, pick(0, 255, 60));
            tmin = pick(0, 4095, 400);
            write_reg(REG_TEMP_MIN, tmin);
            write_reg(REG_TEMP_MAX, pick(tmin, 4095, 4095));
            first = n_items;
            while (n_items - first < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    run = $urandom_range(1, 8);
                    repeat (run) send_tick(1'b0, 1'b0);
                    run = $urandom_range(1, (int'(wet_cfg) + 4 < 60) ? int'(wet_cfg) + 4 : 60);
                    repeat (run) send_tick(1'b1, 1'b0);
                    run = $urandom_range(1, (int'(full_cfg) + 6 < 80) ? int'(full_cfg) + 6 : 80);
                    repeat (run) send_tick(1'b1, 1'b1);
                    run = $urandom_range(1, 10);
                    repeat (run) send_tick(1'b1, 1'b0);
                end
                else
                begin
                    run = $urandom_range(1, 15);
                    repeat (run) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
                end
            end
        end
    endtask

    initial
    begin : sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = snk_idle ? $urandom_range(0, 13) : 0;
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_axis_tvalid);
            check_output(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_DEBOUNCE_LIMIT;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        hold_req      = 1'b0;
        errors        = 0;
        n_items       = 0;
        n_checked     = 0;
        n_writes      = 0;
        n_alarm_ticks = 0;
        n_pump_ticks  = 0;
        debounce_cfg  = DEBOUNCE_RST;
        wet_cfg       = WET_RST;
        full_cfg      = FULL_RST;
        tps_cfg       = TPS_RST;
        timeout_cfg   = TIMEOUT_RST;
        band_cfg      = BAND_RST;
        tmin_cfg      = TEMP_MIN_RST;
        tmax_cfg      = TEMP_MAX_RST;
        low_cnt       = DEBOUNCE_RST;
        high_cnt      = '0;
        tick_div      = '0;
        fill_secs     = '0;
        filling_q     = 1'b0;
        pump_q        = 1'b0;
        cooler_q      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_band_edges();
        test_level_limits();
        test_fill_timer();
        test_backpressure();
        test_random_phases();

        drain_outputs();
        repeat (8) @(posedge clk);
        $display("Sent %0d items over %0d register writes, checked %0d output items.",
                 n_items, n_writes, n_checked);
        $display("Pump ran on %0d ticks, fill alarm reported on %0d ticks.",
                 n_pump_ticks, n_alarm_ticks);
        if (errors == 0 && pending_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
